// ===== src/i2crm_pkg.sv =====
// Shared types and constants for the I2C register master.
package i2crm_pkg;

   // Bus phases, one-hot.
   typedef enum logic [9:0] {
      PH_IDLE   = 10'b0000000001,
      PH_START  = 10'b0000000010,
      PH_ADDR   = 10'b0000000100,
      PH_REGH   = 10'b0000001000,
      PH_REGL   = 10'b0000010000,
      PH_WDATA  = 10'b0000100000,
      PH_RSTART = 10'b0001000000,
      PH_RADDR  = 10'b0010000000,
      PH_RDATA  = 10'b0100000000,
      PH_STOP   = 10'b1000000000
   } phase_type;

   // Request opcodes.
   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_WRITE = 3'd1;
   localparam logic [2:0] OP_READ  = 3'd2;
   localparam logic [2:0] OP_PROBE = 3'd3;
   localparam logic [2:0] OP_LOAD  = 3'd4;

   // Request classes after decode.
   localparam logic [1:0] CLS_NOP  = 2'd0;
   localparam logic [1:0] CLS_TICK = 2'd1;
   localparam logic [1:0] CLS_CMD  = 2'd2;
   localparam logic [1:0] CLS_LOAD = 2'd3;

   // Transfer kinds.
   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;
   localparam logic [1:0] KIND_PROBE = 2'd3;

   // Status codes.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ADDR_NAK = 2'd1;
   localparam logic [1:0] ST_REG_NAK  = 2'd2;
   localparam logic [1:0] ST_DATA_NAK = 2'd3;

   // CSR indexes.
   localparam logic [1:0] CSR_DEV_ADDR = 2'd0;
   localparam logic [1:0] CSR_WIDE     = 2'd1;
   localparam logic [1:0] CSR_TICKS    = 2'd2;

   localparam logic [15:0] TICKS_RESET = 16'd250;
   localparam logic [5:0]  READ_CAP    = 6'd32;
   localparam int          Q_DEPTH     = 4;

   typedef struct packed {
      logic [1:0]  cls;
      logic [1:0]  kind;
      logic        sda;
      logic [15:0] reg_addr;
      logic [5:0]  length;
      logic [7:0]  data;
   } req_type;

   typedef struct packed {
      logic        scl_release;
      logic        sda_release;
      logic        busy;
      logic        done;
      logic [1:0]  status;
      logic        read_valid;
      logic [7:0]  read_byte;
      logic [4:0]  read_index;
   } rsp_type;

   typedef struct packed {
      logic        wr;
      logic [1:0]  index;
      logic [15:0] data;
   } csr_type;

endpackage

// ===== src/i2c_register_master.sv =====
// A request's response is registered as the request leaves the queue.
// One request per cycle is accepted unless req_stall is high; the sequencer updates once per popped request.
// A four-entry queue decouples req_stall from rsp_stall; the response register holds on stall.
// Reset (synchronous, active high) idles the bus, empties the queue and restores the CSRs.
// The write buffer has no reset; entries are valid once loaded.
// Top level: open-drain I2C register master driven by clock-enable tick requests.
module i2c_register_master #(
   parameter int BUF_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic        req_sda_in,
   input  logic [15:0] req_reg_addr,
   input  logic [5:0]  req_length,
   input  logic [7:0]  req_data_byte,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_scl_release,
   output logic        rsp_sda_release,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [1:0]  rsp_status,
   output logic        rsp_read_valid,
   output logic [7:0]  rsp_read_byte,
   output logic [4:0]  rsp_read_index,
   // CSR write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   i2crm_pkg::req_type item, head;
   i2crm_pkg::rsp_type rsp;
   i2crm_pkg::csr_type csr;
   logic push, full, pop, not_empty;

   // CSRs are always writable; the user must see that software writes only while idle; the block does not enforce it
   assign csr_ready = 1'b1;
   assign csr       = '{wr: csr_valid && csr_ready, index: csr_index, data: csr_data};

   // front end: decode and length saturation
   i2crm_front #(.BUF_DEPTH(BUF_DEPTH)) u_front (
      .op_valid   (req_valid),
      .op         (req_op),
      .sda_in     (req_sda_in),
      .reg_addr   (req_reg_addr),
      .length     (req_length),
      .data_byte  (req_data_byte),
      .push       (push),
      .item       (item),
      .queue_full (full),
      .stall      (req_stall)
   );

   i2crm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (item),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   // back end: bus sequencer, write buffer, response register
   i2crm_back #(.BUF_DEPTH(BUF_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .not_empty (not_empty),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_scl_release = rsp.scl_release;
   assign rsp_sda_release = rsp.sda_release;
   assign rsp_busy_res    = rsp.busy;
   assign rsp_done_res    = rsp.done;
   assign rsp_status      = rsp.status;
   assign rsp_read_valid  = rsp.read_valid;
   assign rsp_read_byte   = rsp.read_byte;
   assign rsp_read_index  = rsp.read_index;

   // done comes only as the bus returns to idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("done with bus busy");

   // a received byte is only reported mid-transaction
   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_valid |-> rsp_busy_res && !rsp_done_res)
      else $error("read byte outside transaction");

   // a pop never happens from an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");

   // no read data leaks when nothing was received
   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_read_valid |-> rsp_read_byte == 8'd0 && rsp_read_index == 5'd0)
      else $error("stale read data");
endmodule

// ===== src/i2crm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module i2crm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                 clock,
   input  logic                                 we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                     wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                     rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== src/i2crm_front.sv =====
// Front end: decodes requests into classes and saturates lengths.
module i2crm_front #(
   parameter int BUF_DEPTH = 32
) (
   input  logic        op_valid,
   input  logic [2:0]  op,
   input  logic        sda_in,
   input  logic [15:0] reg_addr,
   input  logic [5:0]  length,
   input  logic [7:0]  data_byte,
   output logic        push,
   output i2crm_pkg::req_type item,
   input  logic        queue_full,
   output logic        stall
);
   always_comb begin
      item          = '0;
      item.sda      = sda_in;
      item.reg_addr = reg_addr;
      item.data     = data_byte;
      item.cls      = i2crm_pkg::CLS_NOP;
      item.kind     = i2crm_pkg::KIND_NONE;
      item.length   = '0;
      case (op)
         i2crm_pkg::OP_TICK: begin
            item.cls = i2crm_pkg::CLS_TICK;
         end
         i2crm_pkg::OP_WRITE: begin
            item.cls    = i2crm_pkg::CLS_CMD;
            item.kind   = i2crm_pkg::KIND_WRITE;
            item.length = (int'(length) > BUF_DEPTH) ? 6'(BUF_DEPTH) : length;
         end
         i2crm_pkg::OP_READ: begin
            item.cls    = i2crm_pkg::CLS_CMD;
            item.kind   = i2crm_pkg::KIND_READ;
            item.length = (length > i2crm_pkg::READ_CAP) ? i2crm_pkg::READ_CAP : length;
         end
         i2crm_pkg::OP_PROBE: begin
            item.cls  = i2crm_pkg::CLS_CMD;
            item.kind = i2crm_pkg::KIND_PROBE;
         end
         i2crm_pkg::OP_LOAD: begin
            item.cls = i2crm_pkg::CLS_LOAD;
         end
         default: begin
            item.cls = i2crm_pkg::CLS_NOP;
         end
      endcase
   end

   assign stall = queue_full;
   assign push  = op_valid && !queue_full;
endmodule

// ===== src/i2crm_queue.sv =====
// Small request queue between front end and bus sequencer.
module i2crm_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  i2crm_pkg::req_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output i2crm_pkg::req_type head
);
   localparam int AW = $clog2(i2crm_pkg::Q_DEPTH);

   i2crm_pkg::req_type slot_ff [i2crm_pkg::Q_DEPTH];
   logic [AW-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [AW:0]   count_ff, count_in;

   always_comb begin
      wptr_in  = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_item;
      end
   end

   assign full      = (count_ff == (AW+1)'(i2crm_pkg::Q_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rptr_ff];
endmodule

// ===== src/i2crm_back.sv =====
// Bus sequencer: quarter-bit timing, byte shifting, write buffer and result register.
module i2crm_back #(
   parameter int BUF_DEPTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  i2crm_pkg::csr_type csr,
   input  logic               not_empty,
   input  i2crm_pkg::req_type head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output i2crm_pkg::rsp_type rsp
);
   localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam int FW = $clog2(BUF_DEPTH + 1) > 0 ? $clog2(BUF_DEPTH + 1) : 1;

   // config
   logic [6:0]  dev_ff;
   logic        wide_ff;
   logic [15:0] ticks_ff;

   // sequencer state
   i2crm_pkg::phase_type ph_ff, ph_in;
   logic [1:0]  q_ff, q_in;
   logic [15:0] tc_ff, tc_in;
   logic [3:0]  bit_ff, bit_in;
   logic [5:0]  byte_ff, byte_in;
   logic [7:0]  shift_ff, shift_in;
   logic        nack_ff, nack_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [1:0]  kind_ff, kind_in;
   logic [15:0] reg_ff, reg_in;
   logic [5:0]  len_ff, len_in;
   logic [1:0]  status_ff, status_in;

   logic rsp_valid_ff, rsp_valid_in;
   i2crm_pkg::rsp_type rsp_ff, rsp_in;

   logic          ram_we;
   logic [AW-1:0] ram_raddr;
   logic [7:0]    ram_rdata;
   logic [5:0]    byte_next;

   assign byte_next = byte_ff + 6'd1;
   assign ram_raddr = (ph_ff == i2crm_pkg::PH_WDATA) ? AW'(byte_next) : '0;

   i2crm_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_buf (
      .clock (clock),
      .we    (ram_we),
      .waddr (AW'(fill_ff)),
      .wdata (head.data),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign pop = not_empty && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      logic [16:0] tick_sum;
      logic [15:0] limit;
      logic        idle;
      logic        high;
      logic [5:0]  bcnt;

      ph_in     = ph_ff;
      q_in      = q_ff;
      tc_in     = tc_ff;
      bit_in    = bit_ff;
      byte_in   = byte_ff;
      shift_in  = shift_ff;
      nack_in   = nack_ff;
      fill_in   = fill_ff;
      kind_in   = kind_ff;
      reg_in    = reg_ff;
      len_in    = len_ff;
      status_in = status_ff;
      ram_we    = 1'b0;
      rsp_in    = '0;
      limit     = (ticks_ff == '0) ? 16'd1 : ticks_ff;
      idle      = (ph_ff == i2crm_pkg::PH_IDLE);
      tick_sum  = {1'b0, tc_ff} + 17'd1;
      bcnt      = '0;

      case (head.cls)
         i2crm_pkg::CLS_TICK: begin
            if (!idle) begin
               if (tick_sum >= {1'b0, limit}) begin
                  tc_in = '0;
                  // sample SDA at the end of the second high quarter
                  if (q_ff == 2'd2) begin
                     if (ph_ff == i2crm_pkg::PH_RDATA) begin
                        if (bit_ff < 4'd8) begin
                           shift_in = {shift_ff[6:0], head.sda};
                           if (bit_ff == 4'd7) begin
                              rsp_in.read_valid = 1'b1;
                              rsp_in.read_byte  = {shift_ff[6:0], head.sda};
                              rsp_in.read_index = byte_ff[4:0];
                           end
                        end
                     end else if ((ph_ff == i2crm_pkg::PH_ADDR ||
                                   ph_ff == i2crm_pkg::PH_REGH ||
                                   ph_ff == i2crm_pkg::PH_REGL ||
                                   ph_ff == i2crm_pkg::PH_WDATA ||
                                   ph_ff == i2crm_pkg::PH_RADDR) && bit_ff == 4'd8) begin
                        nack_in = head.sda;
                     end
                  end
                  if (q_ff != 2'd3) begin
                     q_in = q_ff + 2'd1;
                  end else begin
                     q_in = 2'd0;
                     // end of bit
                     case (ph_ff)
                        i2crm_pkg::PH_START: begin
                           ph_in = i2crm_pkg::PH_ADDR; shift_in = {dev_ff, 1'b0};
                           bit_in = '0; nack_in = 1'b0;
                        end
                        i2crm_pkg::PH_RSTART: begin
                           ph_in = i2crm_pkg::PH_RADDR; shift_in = {dev_ff, 1'b1};
                           bit_in = '0; nack_in = 1'b0;
                        end
                        i2crm_pkg::PH_STOP: begin
                           ph_in = i2crm_pkg::PH_IDLE; bit_in = '0;
                           rsp_in.done = 1'b1;
                           if (kind_ff == i2crm_pkg::KIND_WRITE) begin
                              fill_in = '0;
                           end
                        end
                        i2crm_pkg::PH_RDATA: begin
                           if (bit_ff < 4'd8) begin
                              bit_in = bit_ff + 4'd1;
                           end else begin
                              byte_in = byte_next;
                              bit_in  = '0;
                              if (byte_next >= len_ff) begin
                                 ph_in = i2crm_pkg::PH_STOP;
                              end else begin
                                 shift_in = '0; nack_in = 1'b0;
                              end
                           end
                        end
                        default: begin
                           if (bit_ff < 4'd8) begin
                              bit_in = bit_ff + 4'd1;
                           end else if (nack_ff) begin
                              bit_in = '0;
                              ph_in  = i2crm_pkg::PH_STOP;
                              if (ph_ff == i2crm_pkg::PH_ADDR || ph_ff == i2crm_pkg::PH_RADDR) begin
                                 status_in = i2crm_pkg::ST_ADDR_NAK;
                              end else if (ph_ff == i2crm_pkg::PH_WDATA) begin
                                 status_in = i2crm_pkg::ST_DATA_NAK;
                              end else begin
                                 status_in = i2crm_pkg::ST_REG_NAK;
                              end
                           end else begin
                              bit_in  = '0;
                              nack_in = 1'b0;
                              case (ph_ff)
                                 i2crm_pkg::PH_ADDR: begin
                                    if (kind_ff == i2crm_pkg::KIND_PROBE) begin
                                       ph_in = i2crm_pkg::PH_STOP;
                                    end else if (wide_ff) begin
                                       ph_in = i2crm_pkg::PH_REGH; shift_in = reg_ff[15:8];
                                    end else begin
                                       ph_in = i2crm_pkg::PH_REGL; shift_in = reg_ff[7:0];
                                    end
                                 end
                                 i2crm_pkg::PH_REGH: begin
                                    ph_in = i2crm_pkg::PH_REGL; shift_in = reg_ff[7:0];
                                 end
                                 i2crm_pkg::PH_REGL: begin
                                    if (kind_ff == i2crm_pkg::KIND_READ) begin
                                       ph_in = i2crm_pkg::PH_RSTART;
                                    end else if (len_ff == '0) begin
                                       ph_in = i2crm_pkg::PH_STOP;
                                    end else begin
                                       byte_in = '0;
                                       ph_in = i2crm_pkg::PH_WDATA; shift_in = ram_rdata;
                                    end
                                 end
                                 i2crm_pkg::PH_WDATA: begin
                                    byte_in = byte_next;
                                    if (byte_next >= len_ff) begin
                                       ph_in = i2crm_pkg::PH_STOP;
                                    end else begin
                                       shift_in = ram_rdata;
                                    end
                                 end
                                 i2crm_pkg::PH_RADDR: begin
                                    if (len_ff == '0) begin
                                       ph_in = i2crm_pkg::PH_STOP;
                                    end else begin
                                       byte_in = '0;
                                       ph_in = i2crm_pkg::PH_RDATA; shift_in = '0;
                                    end
                                 end
                                 default: begin
                                    ph_in = i2crm_pkg::PH_STOP;
                                 end
                              endcase
                           end
                        end
                     endcase
                  end
               end else begin
                  tc_in = tick_sum[15:0];
               end
            end
         end
         i2crm_pkg::CLS_CMD: begin
            if (idle) begin
               kind_in   = head.kind;
               reg_in    = head.reg_addr;
               len_in    = head.length;
               status_in = i2crm_pkg::ST_OK;
               byte_in   = '0;
               shift_in  = '0;
               nack_in   = 1'b0;
               tc_in     = '0;
               q_in      = '0;
               bit_in    = '0;
               ph_in     = i2crm_pkg::PH_START;
            end
         end
         i2crm_pkg::CLS_LOAD: begin
            if (idle && fill_ff < FW'(BUF_DEPTH)) begin
               ram_we  = pop;
               fill_in = fill_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase

      // line drives from the new state
      high = (q_in == 2'd1) || (q_in == 2'd2);
      bcnt = byte_in + 6'd1;
      case (ph_in)
         i2crm_pkg::PH_IDLE: begin
            rsp_in.scl_release = 1'b1; rsp_in.sda_release = 1'b1;
         end
         i2crm_pkg::PH_START: begin
            rsp_in.scl_release = (q_in != 2'd3);
            rsp_in.sda_release = (q_in < 2'd2);
         end
         i2crm_pkg::PH_RSTART: begin
            rsp_in.scl_release = (q_in != 2'd3) && (q_in != 2'd0);
            rsp_in.sda_release = (q_in < 2'd2);
         end
         i2crm_pkg::PH_STOP: begin
            rsp_in.scl_release = (q_in != 2'd0);
            rsp_in.sda_release = (q_in >= 2'd2);
         end
         i2crm_pkg::PH_RDATA: begin
            rsp_in.scl_release = high;
            rsp_in.sda_release = (bit_in < 4'd8) ? 1'b1 : !(bcnt < len_in);
         end
         default: begin
            rsp_in.scl_release = high;
            rsp_in.sda_release = (bit_in < 4'd8) ? shift_in[3'd7 - bit_in[2:0]] : 1'b1;
         end
      endcase
      rsp_in.busy   = (ph_in != i2crm_pkg::PH_IDLE);
      rsp_in.status = status_in;

      rsp_valid_in = pop ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_ff       <= '0;
         wide_ff      <= 1'b0;
         ticks_ff     <= i2crm_pkg::TICKS_RESET;
         ph_ff        <= i2crm_pkg::PH_IDLE;
         q_ff         <= '0;
         tc_ff        <= '0;
         bit_ff       <= '0;
         byte_ff      <= '0;
         shift_ff     <= '0;
         nack_ff      <= 1'b0;
         fill_ff      <= '0;
         kind_ff      <= i2crm_pkg::KIND_NONE;
         reg_ff       <= '0;
         len_ff       <= '0;
         status_ff    <= i2crm_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr.wr) begin
            case (csr.index)
               i2crm_pkg::CSR_DEV_ADDR: dev_ff   <= csr.data[6:0];
               i2crm_pkg::CSR_WIDE:     wide_ff  <= csr.data[0];
               i2crm_pkg::CSR_TICKS:    ticks_ff <= csr.data;
               default: begin
               end
            endcase
         end
         if (pop) begin
            ph_in_commit: begin
               ph_ff     <= ph_in;
               q_ff      <= q_in;
               tc_ff     <= tc_in;
               bit_ff    <= bit_in;
               byte_ff   <= byte_in;
               shift_ff  <= shift_in;
               nack_ff   <= nack_in;
               fill_ff   <= fill_in;
               kind_ff   <= kind_in;
               reg_ff    <= reg_in;
               len_ff    <= len_in;
               status_ff <= status_in;
            end
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
endmodule
